// ===== rtl/ktt_pkg.sv =====
// Types, codes and default sizes for the keyed tally table.
`default_nettype none
package ktt_pkg;

	localparam int DEF_TABLE_ENTRIES = 32;
	localparam int DEF_KEY_CHARS     = 8;

	localparam int KEY_W    = 64;
	localparam int CARTON_W = 7;
	localparam int SLOT_W   = 5;
	localparam int SUM_W    = 16;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ACCUM = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_UPDATED  = 2'd0,
		ST_INSERTED = 2'd1,
		ST_FULL     = 2'd2,
		ST_DONE     = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]          op;
		logic [KEY_W-1:0]    product_key;
		logic [CARTON_W-1:0] carton_number;
		logic [SLOT_W-1:0]   slot_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic              slot_valid;
		logic [KEY_W-1:0]  entry_key;
		logic [SUM_W-1:0]  record_count;
		logic [SUM_W-1:0]  carton_total;
		logic [SLOT_W-1:0] last_slot;
	} result_t;

	typedef struct packed {
		op_t                 op;
		logic [KEY_W-1:0]    key;
		logic [CARTON_W-1:0] cartons;
		logic [SLOT_W-1:0]   slot_index;
	} task_t;

endpackage
`default_nettype wire

// ===== rtl/ktt_front.sv =====
// Request intake: key normalization and decode into a queued task.
`default_nettype none
module ktt_front import ktt_pkg::*; #(
	parameter int KEY_CHARS = DEF_KEY_CHARS
) (
	input  wire logic  start,
	input  wire cmd_t  cmd,
	input  wire logic  full,
	output logic       push,
	output task_t      entry
);

	function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] r;
		logic             alive;
		logic [7:0]       ch;
		r     = '0;
		alive = 1'b1;
		for (int b = 0; b < KEY_CHARS; b++) begin
			ch = k[KEY_W-1-8*b -: 8];
			if (ch == 8'd0) begin
				alive = 1'b0;
			end
			if (alive) begin
				r[KEY_W-1-8*b -: 8] = ch;
			end
		end
		return r;
	endfunction

	always_comb begin
		push             = start & ~full;
		entry.op         = op_t'(cmd.op);
		entry.key        = norm_key(cmd.product_key);
		entry.cartons    = cmd.carton_number;
		entry.slot_index = cmd.slot_index;
	end

endmodule
`default_nettype wire

// ===== rtl/ktt_queue.sv =====
// Two-entry task queue between intake and execution.
`default_nettype none
module ktt_queue import ktt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire task_t wr_data,
	input  wire logic  pop,
	output task_t      rd_data,
	output logic       empty,
	output logic       full
);

	task_t      slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = slots_q[rd_ptr_q];
	assign empty   = (fill_q == 2'd0);
	assign full    = (fill_q == 2'd2);

endmodule
`default_nettype wire

// ===== rtl/ktt_back.sv =====
// Execution engine: key scan, tally update, slot read and table clear.
`default_nettype none
module ktt_back import ktt_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  empty,
	input  wire task_t task_in,
	output logic       pop,
	output logic       done,
	output result_t    result
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int XW = ((IW > SLOT_W) ? IW : SLOT_W) + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_FETCH = 5'b00100,
		S_WB    = 5'b01000,
		S_RDOUT = 5'b10000
	} state_t;

	state_t             state_q;
	task_t              cmd_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IW-1:0]      last_q;
	logic [IW-1:0]      ptr_q;
	logic               issue_done_q;
	logic               chk_s1;
	logic [IW-1:0]      idx_s1;
	logic               free_found_q;
	logic [IW-1:0]      free_q;
	logic [IW-1:0]      tgt_q;
	logic               insert_q;
	logic               done_q;
	result_t            result_q;

	logic [KEY_W-1:0]   key_mem [TABLE_ENTRIES];
	logic [SUM_W-1:0]   cnt_mem [TABLE_ENTRIES];
	logic [SUM_W-1:0]   ctn_mem [TABLE_ENTRIES];
	logic [KEY_W-1:0]   key_rd_q;
	logic [SUM_W-1:0]   cnt_rd_q;
	logic [SUM_W-1:0]   ctn_rd_q;

	logic [IW-1:0]      rd_addr;
	logic               mem_we;
	logic [SUM_W-1:0]   cnt_base;
	logic [SUM_W-1:0]   ctn_base;
	logic [SUM_W-1:0]   cnt_new;
	logic [SUM_W:0]     ctn_sum;
	logic [SUM_W-1:0]   ctn_new;
	logic [XW-1:0]      qidx_x;
	logic [XW-1:0]      cidx_x;
	logic [IW-1:0]      cidx;
	logic               cidx_ok;
	logic               hit_now;

	always_comb begin
		qidx_x   = XW'(task_in.slot_index);
		cidx_x   = XW'(cmd_q.slot_index);
		cidx     = cidx_x[IW-1:0];
		cidx_ok  = (cidx_x < XW'(TABLE_ENTRIES));
		hit_now  = chk_s1 && valid_q[idx_s1] && (key_rd_q == cmd_q.key);
		pop      = (state_q == S_IDLE) && !empty;
		mem_we   = (state_q == S_WB);
		cnt_base = insert_q ? '0 : cnt_rd_q;
		ctn_base = insert_q ? '0 : ctn_rd_q;
		cnt_new  = (cnt_base == SUM_MAX) ? SUM_MAX : cnt_base + SUM_W'(1);
		ctn_sum  = {1'b0, ctn_base} + (SUM_W+1)'(cmd_q.cartons);
		ctn_new  = ctn_sum[SUM_W] ? SUM_MAX : ctn_sum[SUM_W-1:0];
		unique case (state_q)
			S_IDLE:  rd_addr = qidx_x[IW-1:0];
			S_SCAN:  rd_addr = ptr_q;
			default: rd_addr = tgt_q;
		endcase
	end

	always_ff @(posedge clk) begin
		key_rd_q <= key_mem[rd_addr];
		cnt_rd_q <= cnt_mem[rd_addr];
		ctn_rd_q <= ctn_mem[rd_addr];
		if (mem_we) begin
			cnt_mem[tgt_q] <= cnt_new;
			ctn_mem[tgt_q] <= ctn_new;
			if (insert_q) begin
				key_mem[tgt_q] <= cmd_q.key;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= task_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			last_q       <= '0;
			ptr_q        <= '0;
			issue_done_q <= 1'b0;
			chk_s1       <= 1'b0;
			idx_s1       <= '0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			tgt_q        <= '0;
			insert_q     <= 1'b0;
			done_q       <= 1'b0;
			result_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						result_q        <= '0;
						result_q.status <= ST_DONE;
						result_q.last_slot <= SLOT_W'(last_q);
						unique case (task_in.op)
							OP_CLEAR: begin
								valid_q            <= '0;
								last_q             <= '0;
								result_q.last_slot <= '0;
								done_q             <= 1'b1;
							end
							OP_ACCUM: begin
								ptr_q        <= '0;
								issue_done_q <= 1'b0;
								chk_s1       <= 1'b0;
								free_found_q <= 1'b0;
								state_q      <= S_SCAN;
							end
							OP_READ: begin
								state_q <= S_RDOUT;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					chk_s1 <= !issue_done_q;
					idx_s1 <= ptr_q;
					if (!issue_done_q) begin
						if (ptr_q == LAST_IDX) begin
							issue_done_q <= 1'b1;
						end else begin
							ptr_q <= ptr_q + IW'(1);
						end
					end
					if (chk_s1 && !valid_q[idx_s1] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q       <= idx_s1;
					end
					if (hit_now) begin
						tgt_q    <= idx_s1;
						insert_q <= 1'b0;
						chk_s1   <= 1'b0;
						state_q  <= S_FETCH;
					end else if (chk_s1 && idx_s1 == LAST_IDX) begin
						chk_s1 <= 1'b0;
						if (free_found_q || !valid_q[idx_s1]) begin
							tgt_q    <= free_found_q ? free_q : idx_s1;
							insert_q <= 1'b1;
							state_q  <= S_FETCH;
						end else begin
							result_q           <= '0;
							result_q.status    <= ST_FULL;
							result_q.last_slot <= SLOT_W'(last_q);
							done_q             <= 1'b1;
							state_q            <= S_IDLE;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_WB;
				end
				S_WB: begin
					valid_q[tgt_q]        <= 1'b1;
					result_q.status       <= insert_q ? ST_INSERTED : ST_UPDATED;
					result_q.slot         <= SLOT_W'(tgt_q);
					result_q.slot_valid   <= 1'b1;
					result_q.entry_key    <= cmd_q.key;
					result_q.record_count <= cnt_new;
					result_q.carton_total <= ctn_new;
					if (insert_q) begin
						last_q             <= tgt_q;
						result_q.last_slot <= SLOT_W'(tgt_q);
					end else begin
						result_q.last_slot <= SLOT_W'(last_q);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RDOUT: begin
					result_q.status    <= ST_DONE;
					result_q.slot      <= cmd_q.slot_index;
					result_q.last_slot <= SLOT_W'(last_q);
					if (cidx_ok && valid_q[cidx]) begin
						result_q.slot_valid   <= 1'b1;
						result_q.entry_key    <= key_rd_q;
						result_q.record_count <= cnt_rd_q;
						result_q.carton_total <= ctn_rd_q;
					end else begin
						result_q.slot_valid   <= 1'b0;
						result_q.entry_key    <= '0;
						result_q.record_count <= '0;
						result_q.carton_total <= '0;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ===== rtl/keyed_tally_table_core.sv =====
// Top level of the keyed tally table: intake, task queue and execution engine.
//
//   channel   accept           payload   fields
//   request   start & !busy    cmd       op, product_key, carton_number, slot_index
//   result    done (1 cycle)   result    status, slot, slot_valid, entry_key, sums, last_slot
//
// Accumulate goes from the queue head through the key scan, fetch and write-back to done; the
// scan stops at the first hit, and runs through every slot for an insert or a hit in the last
// slot; a full table drops the request when the scan ends. The scan checks one key per cycle.
// Read goes from the queue head through the readout state to done; clear and unused ops finish from idle.
// Two requests queue ahead of the engine; busy rises only when both are held.
// The result receiver cannot stall. Reset empties the table through the valid bits.
`default_nettype none
module keyed_tally_table_core import ktt_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int KEY_CHARS     = DEF_KEY_CHARS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire cmd_t cmd,
	output logic      done,
	output result_t   result
);

	logic  push;
	logic  pop;
	logic  empty;
	logic  full;
	task_t wr_task;
	task_t rd_task;

	ktt_front #(
		.KEY_CHARS(KEY_CHARS)
	) u_front (
		.start(start),
		.cmd  (cmd),
		.full (full),
		.push (push),
		.entry(wr_task)
	);

	ktt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(wr_task),
		.pop    (pop),
		.rd_data(rd_task),
		.empty  (empty),
		.full   (full)
	);

	ktt_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.task_in(rd_task),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

	assign busy = full;

endmodule
`default_nettype wire
